FILE: hw/rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types and constants for the set membership table: request and
// status codes, key geometry and the control word carried down the cell chain.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int KEY_WORDS         = 8;
  localparam int WORD_W            = 64;
  localparam int KEY_W             = KEY_WORDS * WORD_W;
  localparam int COUNT_OUT_W       = 8;

  typedef logic [1:0]             req_t;
  typedef logic [1:0]             status_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_MATCH = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;
  localparam req_t REQ_BAD   = 2'd3;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  typedef struct packed {
    logic       vld;
    req_t       req;
    logic       found;
    status_t    status;
    logic       last;
    count_out_t count;
  } ctl_t;

endpackage

FILE: hw/rtl/hsm_in_if.sv
// ----------------------------------------------------------------------------
// hsm_in_if
// Request channel: valid/ready handshake with request kind, 512-bit key
// split into eight 64-bit words, and the batch end mark.
// ----------------------------------------------------------------------------
interface hsm_in_if;
  import hsm_pkg::*;

  logic  valid;
  logic  ready;
  req_t  req_type;
  word_t key_word_0;
  word_t key_word_1;
  word_t key_word_2;
  word_t key_word_3;
  word_t key_word_4;
  word_t key_word_5;
  word_t key_word_6;
  word_t key_word_7;
  logic  batch_last;

  modport source (
    output valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
           key_word_4, key_word_5, key_word_6, key_word_7, batch_last,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_word_0, key_word_1, key_word_2, key_word_3,
           key_word_4, key_word_5, key_word_6, key_word_7, batch_last,
    output ready
  );
endinterface

FILE: hw/rtl/hsm_out_if.sv
// ----------------------------------------------------------------------------
// hsm_out_if
// Result channel: valid/ready handshake with match flag, status, fill count
// and batch end mark.
// ----------------------------------------------------------------------------
interface hsm_out_if;
  import hsm_pkg::*;

  logic       valid;
  logic       ready;
  logic       found;
  status_t    status;
  count_out_t stored_count;
  logic       last_out;

  modport source (
    output valid, found, status, stored_count, last_out,
    input  ready
  );

  modport sink (
    input  valid, found, status, stored_count, last_out,
    output ready
  );
endinterface

FILE: hw/rtl/hsm_cell.sv
// ----------------------------------------------------------------------------
// hsm_cell
// One table slot. Holds one stored key, writes it when a load aimed at this
// slot passes, compares passing match words against it and hands the word on.
// ----------------------------------------------------------------------------
module hsm_cell #(
  parameter int TABLE_ENTRIES = hsm_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX           = 0,
  parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  hsm_pkg::ctl_t        ctl_i,
  input  hsm_pkg::key_t        key_i,
  input  logic [CW-1:0]        snap_i,
  output hsm_pkg::ctl_t        ctl_o,
  output hsm_pkg::key_t        key_o,
  output logic [CW-1:0]        snap_o
);
  import hsm_pkg::*;

  localparam logic [CW-1:0] SLOT = CW'(IDX);

  key_t          slot_key_r;
  ctl_t          ctl_r;
  ctl_t          ctl_nxt;
  key_t          key_r;
  logic [CW-1:0] snap_r;
  logic          hit;
  logic          wr_en;

  assign hit   = ctl_i.vld && (ctl_i.req == REQ_MATCH) && (SLOT < snap_i)
                 && (slot_key_r == key_i);
  assign wr_en = adv && ctl_i.vld && (ctl_i.req == REQ_LOAD) && (snap_i == SLOT);

  always_comb begin
    ctl_nxt       = ctl_i;
    ctl_nxt.found = ctl_i.found | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r.vld <= ctl_nxt.vld;
    end
    if (adv) begin
      ctl_r.req    <= ctl_nxt.req;
      ctl_r.found  <= ctl_nxt.found;
      ctl_r.status <= ctl_nxt.status;
      ctl_r.last   <= ctl_nxt.last;
      ctl_r.count  <= ctl_nxt.count;
      key_r        <= key_i;
      snap_r       <= snap_i;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_key_r <= key_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign key_o  = key_r;
  assign snap_o = snap_r;

endmodule

FILE: hw/rtl/hash_set_membership_table_top.sv
// ----------------------------------------------------------------------------
// hash_set_membership_table_top
// Set membership table of up to TABLE_ENTRIES 512-bit keys with a fill count.
// ----------------------------------------------------------------------------
// Requests enter a head stage that updates the fill count, sets status, count
// and batch mark, then travel down a chain of TABLE_ENTRIES slot cells, one
// cell per cycle; each cell stores one key and folds its compare into the
// found flag. A result is presented from the register of the last cell, and
// one request per cycle is accepted in steady state; the chain moves as a
// whole, so it holds while a result waits at the output. Each
// request carries the count seen at entry, so a match only looks at slots
// loaded before it and a clear takes effect for all later requests.
module hash_set_membership_table_top #(
  parameter int TABLE_ENTRIES = hsm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hsm_in_if.sink    in_if,
  hsm_out_if.source out_if
);
  import hsm_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  logic          adv;
  logic          acc;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  status_t       status_nxt;
  logic          last_nxt;
  key_t          key_in;

  ctl_t          st_ctl  [TABLE_ENTRIES+1];
  key_t          st_key  [TABLE_ENTRIES+1];
  logic [CW-1:0] st_snap [TABLE_ENTRIES+1];

  assign adv          = !st_ctl[TABLE_ENTRIES].vld || out_if.ready;
  assign in_if.ready  = adv;
  assign acc          = in_if.valid && adv;

  assign key_in = {in_if.key_word_7, in_if.key_word_6, in_if.key_word_5,
                   in_if.key_word_4, in_if.key_word_3, in_if.key_word_2,
                   in_if.key_word_1, in_if.key_word_0};

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    case (in_if.req_type)
      REQ_LOAD: begin
        if (count_r >= FULL) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_MATCH: begin
        last_nxt = in_if.batch_last;
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_BAD;
      end
    endcase
  end

  // fill count and head stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      st_ctl[0].vld <= 1'b0;
    end else if (adv) begin
      st_ctl[0].vld <= in_if.valid;
      if (in_if.valid) begin
        count_r <= count_nxt;
      end
    end
    if (acc) begin
      st_ctl[0].req    <= in_if.req_type;
      st_ctl[0].found  <= 1'b0;
      st_ctl[0].status <= status_nxt;
      st_ctl[0].last   <= last_nxt;
      st_ctl[0].count  <= COUNT_OUT_W'(count_nxt);
      st_key[0]        <= key_in;
      st_snap[0]       <= count_r;
    end
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    hsm_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX           (k),
      .CW            (CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (st_ctl[k]),
      .key_i  (st_key[k]),
      .snap_i (st_snap[k]),
      .ctl_o  (st_ctl[k+1]),
      .key_o  (st_key[k+1]),
      .snap_o (st_snap[k+1])
    );
  end

  assign out_if.valid        = st_ctl[TABLE_ENTRIES].vld;
  assign out_if.found        = st_ctl[TABLE_ENTRIES].found;
  assign out_if.status       = st_ctl[TABLE_ENTRIES].status;
  assign out_if.stored_count = st_ctl[TABLE_ENTRIES].count;
  assign out_if.last_out     = st_ctl[TABLE_ENTRIES].last;

endmodule

FILE: bench/hash_set_membership_table_checker.sv
// ----------------------------------------------------------------------------
// hash_set_membership_table_checker
// Watches the request and result channels of the set membership table. Every
// accepted request word updates a local copy of the key table and fill count
// and queues the answer it must produce; every accepted result word is compared
// field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module hash_set_membership_table_checker #(
  parameter int TABLE_ENTRIES = hsm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hsm_in_if    in_mon,
  hsm_out_if   out_mon,
  output int   fail_count,
  output int   answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import hsm_pkg::*;

  typedef struct packed {
    logic       found;
    status_t    status;
    count_out_t count;
    logic       last;
  } answer_t;

  key_t        slot_key [TABLE_ENTRIES];
  int unsigned fill;
  int          misses;
  answer_t     answer_q [$];
  answer_t     got;
  answer_t     want;
  key_t        req_key;

  // applies one request to the local table and returns its answer
  function automatic answer_t table_answer(req_t req, key_t key, logic batch_end);
    answer_t a;
    a.found  = 1'b0;
    a.status = ST_OK;
    a.last   = 1'b1;
    case (req)
      REQ_LOAD: begin
        if (fill >= TABLE_ENTRIES) begin
          a.status = ST_FULL;
        end else begin
          slot_key[fill] = key;
          fill++;
        end
      end
      REQ_MATCH: begin
        for (int s = 0; s < fill; s++) begin
          if (slot_key[s] == key) a.found = 1'b1;
        end
        a.last = batch_end;
      end
      REQ_CLEAR: begin
        fill = 0;
      end
      default: begin
        a.status = ST_BAD;
      end
    endcase
    a.count = count_out_t'(fill);
    return a;
  endfunction

  function automatic void report_miss(string what, answer_t exp_a, answer_t act_a);
    misses++;
    if (misses <= 10) begin
      $display("%0t %s: expected found=%0b status=%0d count=%0d last=%0b",
               $realtime, what, exp_a.found, exp_a.status, exp_a.count, exp_a.last);
      $display("%0t %s:   actual found=%0b status=%0d count=%0d last=%0b",
               $realtime, what, act_a.found, act_a.status, act_a.count, act_a.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill   = 0;
      misses = 0;
      answer_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.found  = out_mon.found;
        got.status = out_mon.status;
        got.count  = out_mon.stored_count;
        got.last   = out_mon.last_out;
        if (answer_q.size() == 0) begin
          report_miss("result word with none due", '0, got);
        end else begin
          want = answer_q.pop_front();
          if (got.found !== want.found || got.status !== want.status ||
              got.count !== want.count || got.last !== want.last) begin
            report_miss("result word mismatch", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req_key = {in_mon.key_word_7, in_mon.key_word_6, in_mon.key_word_5,
                   in_mon.key_word_4, in_mon.key_word_3, in_mon.key_word_2,
                   in_mon.key_word_1, in_mon.key_word_0};
        answer_q.push_back(table_answer(in_mon.req_type, req_key, in_mon.batch_last));
      end
    end
    fail_count  <= misses;
    answers_due <= answer_q.size();
  end

endmodule

FILE: bench/hash_set_membership_table_top_tb.sv
// ----------------------------------------------------------------------------
// hash_set_membership_table_top_tb
// Drives load, match, clear and bad requests into the set membership table:
// a short directed run over empty, stale, near-miss and extreme keys, then
// three random phases that fill the table, overflow it and mix hits, misses
// and clears under changing sender and receiver stalls. The checker predicts
// and compares; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module hash_set_membership_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsm_pkg::*;

  localparam int ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int DRAIN       = ENTRIES + 1;
  localparam int PHASE_WORDS = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   tx_idle = 8;
  int   rx_idle = 52;
  int   fail_count;
  int   answers_due;

  // keys loaded so far, used to aim match requests at live and stale slots and to repeat loads of stored keys
  key_t issued [ENTRIES];
  int   fill = 0;
  int   ever = 0;

  hsm_in_if  req_ch ();
  hsm_out_if res_ch ();

  hash_set_membership_table_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch)
  );

  hash_set_membership_table_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (req_ch),
    .out_mon    (res_ch),
    .fail_count (fail_count),
    .answers_due(answers_due)
  );

  always #1ns clk = ~clk;

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic key_t random_key();
    key_t k;
    k = '0;
    for (int i = 0; i < KEY_W / 32; i++) k = {k[KEY_W-33:0], $urandom()};
    return k;
  endfunction

  // live key, stale key, live key with one bit flipped, or a fresh key
  function automatic key_t probe_key();
    int   r;
    key_t k;
    r = $urandom_range(99);
    if (fill > 0 && r < 50) begin
      k = issued[$urandom_range(fill - 1)];
    end else if (ever > fill && r < 65) begin
      k = issued[$urandom_range(ever - 1, fill)];
    end else if (fill > 0 && r < 80) begin
      k = issued[$urandom_range(fill - 1)];
      k[$urandom_range(KEY_W - 1)] ^= 1'b1;
    end else begin
      k = random_key();
    end
    return k;
  endfunction

  task automatic send_word(req_t req, key_t key, logic batch_end);
    while ($urandom_range(99) < tx_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= req;
    req_ch.key_word_0 <= key[63:0];
    req_ch.key_word_1 <= key[127:64];
    req_ch.key_word_2 <= key[191:128];
    req_ch.key_word_3 <= key[255:192];
    req_ch.key_word_4 <= key[319:256];
    req_ch.key_word_5 <= key[383:320];
    req_ch.key_word_6 <= key[447:384];
    req_ch.key_word_7 <= key[511:448];
    req_ch.batch_last <= batch_end;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (req == REQ_LOAD && fill < ENTRIES) begin
      issued[fill] = key;
      fill++;
      if (fill > ever) ever = fill;
    end else if (req == REQ_CLEAR) begin
      fill = 0;
    end
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
  endtask

  task automatic run_phase(int tx, int rx, int fill_target);
    int   r;
    key_t k;
    tx_idle = tx;
    rx_idle = rx;
    send_word(REQ_CLEAR, random_key(), 1'($urandom_range(1)));
    repeat (fill_target) send_word(REQ_LOAD, random_key(), 1'($urandom_range(1)));
    repeat (PHASE_WORDS - fill_target - 1) begin
      r = $urandom_range(99);
      if (r < 30) begin
        if (fill > 0 && $urandom_range(6) == 0) k = issued[$urandom_range(fill - 1)];
        else k = random_key();
        send_word(REQ_LOAD, k, 1'($urandom_range(1)));
      end else if (r < 85) begin
        send_word(REQ_MATCH, probe_key(), 1'($urandom_range(1)));
      end else if (r < 95) begin
        send_word(REQ_BAD, random_key(), 1'($urandom_range(1)));
      end else begin
        send_word(REQ_CLEAR, random_key(), 1'($urandom_range(1)));
      end
    end
    hold_until_drained();
  endtask

  initial begin
    key_t k;
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD;
    req_ch.key_word_0 <= '0;
    req_ch.key_word_1 <= '0;
    req_ch.key_word_2 <= '0;
    req_ch.key_word_3 <= '0;
    req_ch.key_word_4 <= '0;
    req_ch.key_word_5 <= '0;
    req_ch.key_word_6 <= '0;
    req_ch.key_word_7 <= '0;
    req_ch.batch_last <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, zero and all-ones keys
    send_word(REQ_MATCH, '0, 1'b1);
    send_word(REQ_LOAD, '0, 1'b0);
    send_word(REQ_MATCH, '0, 1'b0);
    send_word(REQ_LOAD, '1, 1'b1);
    send_word(REQ_MATCH, '1, 1'b1);
    // near misses at the top and bottom key bits
    k = '1;
    k[KEY_W-1] = 1'b0;
    send_word(REQ_MATCH, k, 1'b0);
    k = '1;
    k[0] = 1'b0;
    send_word(REQ_MATCH, k, 1'b1);
    send_word(REQ_BAD, '1, 1'b0);
    send_word(REQ_BAD, '0, 1'b1);
    // stale keys after a clear must miss
    send_word(REQ_CLEAR, '1, 1'b0);
    send_word(REQ_MATCH, '1, 1'b1);
    send_word(REQ_MATCH, '0, 1'b0);
    k = random_key();
    send_word(REQ_LOAD, k, 1'b1);
    send_word(REQ_MATCH, k, 1'b0);
    send_word(REQ_LOAD, k, 1'b0);
    send_word(REQ_MATCH, k, 1'b1);
    send_word(REQ_CLEAR, '0, 1'b1);
    send_word(REQ_CLEAR, '0, 1'b0);
    send_word(REQ_LOAD, random_key(), 1'b0);
    hold_until_drained();

    run_phase(8, 52, ENTRIES + 3);
    run_phase(52, 8, $urandom_range(ENTRIES));
    run_phase(0, 0, ENTRIES);

    repeat (2 * DRAIN) @(posedge clk);
    if (fail_count == 0 && answers_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: hash_set_membership_table_top.f
hw/rtl/hsm_pkg.sv
hw/rtl/hsm_in_if.sv
hw/rtl/hsm_out_if.sv
hw/rtl/hsm_cell.sv
hw/rtl/hash_set_membership_table_top.sv
bench/hash_set_membership_table_checker.sv
bench/hash_set_membership_table_top_tb.sv
